FILE: rtl/utf8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

  localparam int CpWidth    = 21;
  localparam int CountWidth = 16;
  localparam int CapWidth   = 17;

  // end-of-string status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // one result beat
  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic                  char_valid;
    logic                  string_done;
    status_t               status;
    logic [CountWidth-1:0] char_count;
  } result_t;

  // byte class masks and patterns
  localparam logic [7:0] MaskLead2 = 8'hE0;
  localparam logic [7:0] PatLead2  = 8'hC0;
  localparam logic [7:0] MaskLead3 = 8'hF0;
  localparam logic [7:0] PatLead3  = 8'hE0;
  localparam logic [7:0] MaskLead4 = 8'hF8;
  localparam logic [7:0] PatLead4  = 8'hF0;
  localparam logic [7:0] MaskCont  = 8'hC0;
  localparam logic [7:0] PatCont   = 8'h80;
  localparam logic [7:0] MaskBits  = 8'h3F;

  // largest character limit
  localparam logic [CountWidth-1:0] LimitMax = '1;
  // limit after reset: capacity 256 minus the terminator
  localparam logic [CountWidth-1:0] LimitReset = 16'd255;

endpackage
`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into 21-bit code points with end-of-string
// status and character count.
// ----------------------------------------------------------------------------
// Input channel: byte_in and last_byte, moved by byte_valid / byte_stall.
// Output channel: code_point, char_valid, string_done, status, char_count,
// moved by result_valid / result_stall. A byte gives zero or one result beat.
// A result beat is registered: it goes to the output register, or to the skid register while the output beat is held.
// Throughput: one byte per cycle while byte_stall is low; the decode state
// (accumulator, pending continuation count, character count, stop flag) is
// updated in the same cycle the byte is taken, so the loop through that state sets the figure.
// When the receiver stalls, the output register holds its beat and a skid
// register takes one more; byte_stall rises only while the skid is full.
// out_capacity is to be written through out_capacity_we only while the block is idle; the block does not enforce it;
// it is stored as the character limit (capacity minus one, saturated).
// Reset (rst, synchronous) clears the string state, empties both output
// registers and sets the capacity to 256.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                out_capacity_we,
  input  wire logic [utf8_pkg::CapWidth-1:0]       out_capacity,
  // byte channel
  input  wire logic                                byte_valid,
  output logic                                     byte_stall,
  input  wire logic [7:0]                          byte_in,
  input  wire logic                                last_byte,
  // result channel
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic [utf8_pkg::CpWidth-1:0]             code_point,
  output logic                                     char_valid,
  output logic                                     string_done,
  output utf8_pkg::status_t                        status,
  output logic [utf8_pkg::CountWidth-1:0]          char_count
);
  import utf8_pkg::*;

  // decode state
  logic [CountWidth-1:0] limit;
  logic [CpWidth-1:0]    accumulator, accumulator_next;
  logic [1:0]            pending, pending_next;
  logic [CountWidth-1:0] emitted_count, emitted_count_next;
  logic                  stopped, stopped_next;

  // output register and skid
  result_t out_beat, skid_beat, new_beat;
  logic    skid_valid;
  logic    produce;

  logic accept, take;
  logic [CpWidth-1:0] shifted;

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !byte_stall;
  assign take       = result_valid && !result_stall;
  assign shifted    = {accumulator[CpWidth-7:0], byte_in[5:0]};

  // character limit from capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (out_capacity_we) begin
      if (out_capacity[CapWidth-1]) begin
        limit <= LimitMax;
      end else if (out_capacity == '0) begin
        limit <= '0;
      end else begin
        limit <= out_capacity[CountWidth-1:0] - 1'b1;
      end
    end
  end

  // per-byte decode
  always_comb begin
    accumulator_next   = accumulator;
    pending_next       = pending;
    emitted_count_next = emitted_count;
    stopped_next       = stopped;
    produce            = 1'b0;
    new_beat.code_point  = '0;
    new_beat.char_valid  = 1'b0;
    new_beat.string_done = 1'b0;
    new_beat.status      = ST_OK;
    new_beat.char_count  = emitted_count;

    if (stopped) begin
      // ignore bytes until the last one
      if (last_byte) begin
        accumulator_next   = '0;
        pending_next       = '0;
        emitted_count_next = '0;
        stopped_next       = 1'b0;
      end
    end else if (pending != 2'd0) begin
      // inside a multi-byte sequence
      if (last_byte && pending > 2'd1) begin
        produce              = 1'b1;
        new_beat.string_done = 1'b1;
        new_beat.status      = ST_TRUNC;
      end else if ((byte_in & MaskCont) != PatCont) begin
        produce              = 1'b1;
        new_beat.string_done = 1'b1;
        new_beat.status      = ST_BAD_CONT;
      end else begin
        pending_next = pending - 2'd1;
        if (pending == 2'd1) begin
          accumulator_next     = '0;
          produce              = 1'b1;
          emitted_count_next   = emitted_count + 1'b1;
          new_beat.code_point  = shifted;
          new_beat.char_valid  = 1'b1;
          new_beat.string_done = last_byte;
          new_beat.char_count  = emitted_count + 1'b1;
        end else begin
          accumulator_next = shifted;
        end
      end
    end else begin
      // at a character start
      if (byte_in == 8'd0) begin
        produce              = 1'b1;
        new_beat.string_done = 1'b1;
        new_beat.status      = ST_OK;
      end else if (emitted_count >= limit) begin
        produce              = 1'b1;
        new_beat.string_done = 1'b1;
        new_beat.status      = ST_FULL;
      end else if (!byte_in[7]) begin
        produce              = 1'b1;
        emitted_count_next   = emitted_count + 1'b1;
        new_beat.code_point  = {{(CpWidth-8){1'b0}}, byte_in};
        new_beat.char_valid  = 1'b1;
        new_beat.string_done = last_byte;
        new_beat.char_count  = emitted_count + 1'b1;
      end else if ((byte_in & MaskLead2) == PatLead2 ||
                   (byte_in & MaskLead3) == PatLead3 ||
                   (byte_in & MaskLead4) == PatLead4) begin
        if (last_byte) begin
          produce              = 1'b1;
          new_beat.string_done = 1'b1;
          new_beat.status      = ST_TRUNC;
        end else if ((byte_in & MaskLead2) == PatLead2) begin
          accumulator_next = {{(CpWidth-5){1'b0}}, byte_in[4:0]};
          pending_next     = 2'd1;
        end else if ((byte_in & MaskLead3) == PatLead3) begin
          accumulator_next = {{(CpWidth-4){1'b0}}, byte_in[3:0]};
          pending_next     = 2'd2;
        end else begin
          accumulator_next = {{(CpWidth-3){1'b0}}, byte_in[2:0]};
          pending_next     = 2'd3;
        end
      end else begin
        produce              = 1'b1;
        new_beat.string_done = 1'b1;
        new_beat.status      = ST_BAD_LEAD;
      end
    end

    // end of string: clear on the last byte, else wait for it
    if (!stopped && produce && new_beat.string_done) begin
      if (last_byte) begin
        accumulator_next   = '0;
        pending_next       = '0;
        emitted_count_next = '0;
        stopped_next       = 1'b0;
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      pending       <= '0;
      emitted_count <= '0;
      stopped       <= 1'b0;
    end else if (accept) begin
      accumulator   <= accumulator_next;
      pending       <= pending_next;
      emitted_count <= emitted_count_next;
      stopped       <= stopped_next;
    end
  end

  // output register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_beat   <= skid_beat;
        skid_valid <= 1'b0;
      end
    end else if (accept && produce) begin
      if (!result_valid || take) begin
        out_beat     <= new_beat;
        result_valid <= 1'b1;
      end else begin
        skid_beat  <= new_beat;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  assign code_point  = out_beat.code_point;
  assign char_valid  = out_beat.char_valid;
  assign string_done = out_beat.string_done;
  assign status      = out_beat.status;
  assign char_count  = out_beat.char_count;

  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a beat while output register is empty");

  // every beat carries a character or ends a string
  a_beat_meaning: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (char_valid || string_done))
    else $error("result beat with neither character nor end of string");

  // a character beat always reports ok status
  a_char_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && char_valid) |-> (status == ST_OK))
    else $error("character beat with error status");

  // a taken stopping byte that is not last leaves the decoder stopped
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && produce && new_beat.string_done && !last_byte) |=> stopped)
    else $error("decoder not stopped after end of string");

endmodule
`default_nettype wire
